// ===== hw/rtl/mmrf_pkg.sv =====
package mmrf_pkg;

   localparam int NODE_COUNT_DEF = 16;
   localparam int PEER_SLOTS_DEF = 8;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] CMD_MESSAGE     = 2'd0;
   localparam logic [1:0] CMD_ROUTE_WRITE = 2'd1;
   localparam logic [1:0] CMD_ROUTE_CLEAR = 2'd2;

   localparam logic [1:0] REG_OWN_NODE_ID    = 2'd0;
   localparam logic [1:0] REG_BROADCAST_ID   = 2'd1;
   localparam logic [1:0] REG_LISTENER_PORTS = 2'd2;
   localparam logic [1:0] REG_HOP_LIMIT      = 2'd3;

   localparam logic [3:0] V_DELIVER       = 4'd0;
   localparam logic [3:0] V_SHORT         = 4'd1;
   localparam logic [3:0] V_DUPLICATE     = 4'd2;
   localparam logic [3:0] V_NO_LISTENER   = 4'd3;
   localparam logic [3:0] V_LISTENER_FULL = 4'd4;
   localparam logic [3:0] V_RETURNED      = 4'd5;
   localparam logic [3:0] V_HOP_LIMIT     = 4'd6;
   localparam logic [3:0] V_QUEUE_FULL    = 4'd7;
   localparam logic [3:0] V_NO_ROUTE      = 4'd8;
   localparam logic [3:0] V_FORWARD       = 4'd9;

   localparam logic [6:0] HDR_BYTES  = 7'd5;
   localparam logic [7:0] ROUTE_NONE = 8'hFF;

   localparam logic [7:0]  OWN_NODE_ID_RST    = 8'd1;
   localparam logic [7:0]  BROADCAST_ID_RST   = 8'd255;
   localparam logic [15:0] LISTENER_PORTS_RST = 16'd0;
   localparam logic [3:0]  HOP_LIMIT_RST      = 4'd8;

   typedef struct packed {
      logic [7:0]  own_node_id;
      logic [7:0]  broadcast_id;
      logic [15:0] listener_ports;
      logic [3:0]  hop_limit;
   } cfg_type;

endpackage

// ===== hw/rtl/mesh_message_receive_filter.sv =====
// Mesh message receive filter. Each req_ item is either a received message header
// (command message) or a route table command (write or clear one forwarding entry).
// Every item yields exactly one rsp_ item: verdict, relay node and delivered data length.
// Node id, broadcast id, listener port mask and hop limit sit in csr_ registers,
// which the user must write over the APB-style port only while no item is in flight;
// the block itself does not enforce this. After acceptance every item passes a decide
// state and a finish state that fills the output register; messages that look up the
// route table add a route check state (one registered read), and messages addressed
// to this node or broadcast add a serial scan of the peer table, one slot per cycle
// through a single id comparator, that stops at the sender's slot or runs through
// every slot for a new sender, and then a peer update state. A new item is taken in
// the cycle after the previous result has moved into the output register, so the block
// takes no new item before it is through with the last one.
// The output register frees the input side: while the receiver holds rsp_ready low
// the next item is accepted and worked on, and waits only when its own result is ready.
// Reset (synchronous, active high) restores the registers to their defaults, marks
// every route entry as no route and empties the peer table; no clearing pass is needed.
module mesh_message_receive_filter #(
   parameter int NODE_COUNT = mmrf_pkg::NODE_COUNT_DEF,
   parameter int PEER_SLOTS = mmrf_pkg::PEER_SLOTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [mmrf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mmrf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [mmrf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_command,
   input  logic [6:0]                      req_payload_length,
   input  logic [7:0]                      req_sender,
   input  logic [7:0]                      req_recipient,
   input  logic [7:0]                      req_sequence_req,
   input  logic [7:0]                      req_port,
   input  logic [7:0]                      req_hop_count,
   input  logic                            req_listener_queue_full,
   input  logic                            req_send_queue_full,
   input  logic [3:0]                      req_route_destination,
   input  logic [7:0]                      req_route_relay_node,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [3:0]                      rsp_verdict,
   output logic [7:0]                      rsp_relay_node,
   output logic [6:0]                      rsp_data_length
);

   mmrf_pkg::cfg_type cfg;

   mmrf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mmrf_ctrl #(
      .NODE_COUNT (NODE_COUNT),
      .PEER_SLOTS (PEER_SLOTS)
   ) u_ctrl (
      .clock                   (clock),
      .reset                   (reset),
      .cfg                     (cfg),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_command             (req_command),
      .req_payload_length      (req_payload_length),
      .req_sender              (req_sender),
      .req_recipient           (req_recipient),
      .req_sequence_req        (req_sequence_req),
      .req_port                (req_port),
      .req_hop_count           (req_hop_count),
      .req_listener_queue_full (req_listener_queue_full),
      .req_send_queue_full     (req_send_queue_full),
      .req_route_destination   (req_route_destination),
      .req_route_relay_node    (req_route_relay_node),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_verdict             (rsp_verdict),
      .rsp_relay_node          (rsp_relay_node),
      .rsp_data_length         (rsp_data_length)
   );

endmodule

// ===== hw/rtl/mmrf_ram.sv =====
module mmrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/mmrf_csr.sv =====
module mmrf_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [mmrf_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [mmrf_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [mmrf_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready,
   output mmrf_pkg::cfg_type                  cfg
);

   mmrf_pkg::cfg_type cfg_ff, cfg_in;
   logic [1:0]        reg_sel;
   logic              wr_strobe;

   assign reg_sel   = csr_paddr[3:2];
   assign wr_strobe = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_strobe) begin
         case (reg_sel)
            mmrf_pkg::REG_OWN_NODE_ID:    cfg_in.own_node_id    = csr_pwdata[7:0];
            mmrf_pkg::REG_BROADCAST_ID:   cfg_in.broadcast_id   = csr_pwdata[7:0];
            mmrf_pkg::REG_LISTENER_PORTS: cfg_in.listener_ports = csr_pwdata[15:0];
            mmrf_pkg::REG_HOP_LIMIT:      cfg_in.hop_limit      = csr_pwdata[3:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_node_id    <= mmrf_pkg::OWN_NODE_ID_RST;
         cfg_ff.broadcast_id   <= mmrf_pkg::BROADCAST_ID_RST;
         cfg_ff.listener_ports <= mmrf_pkg::LISTENER_PORTS_RST;
         cfg_ff.hop_limit      <= mmrf_pkg::HOP_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_sel)
         mmrf_pkg::REG_OWN_NODE_ID:    csr_prdata = {24'd0, cfg_ff.own_node_id};
         mmrf_pkg::REG_BROADCAST_ID:   csr_prdata = {24'd0, cfg_ff.broadcast_id};
         mmrf_pkg::REG_LISTENER_PORTS: csr_prdata = {16'd0, cfg_ff.listener_ports};
         mmrf_pkg::REG_HOP_LIMIT:      csr_prdata = {28'd0, cfg_ff.hop_limit};
         default:                      csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

// ===== hw/rtl/mmrf_ctrl.sv =====
module mmrf_ctrl #(
   parameter int NODE_COUNT = mmrf_pkg::NODE_COUNT_DEF,
   parameter int PEER_SLOTS = mmrf_pkg::PEER_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  mmrf_pkg::cfg_type cfg,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_command,
   input  logic [6:0]        req_payload_length,
   input  logic [7:0]        req_sender,
   input  logic [7:0]        req_recipient,
   input  logic [7:0]        req_sequence_req,
   input  logic [7:0]        req_port,
   input  logic [7:0]        req_hop_count,
   input  logic              req_listener_queue_full,
   input  logic              req_send_queue_full,
   input  logic [3:0]        req_route_destination,
   input  logic [7:0]        req_route_relay_node,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [3:0]        rsp_verdict,
   output logic [7:0]        rsp_relay_node,
   output logic [6:0]        rsp_data_length
);

   localparam int NW = $clog2(NODE_COUNT);
   localparam int PW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
   localparam logic [8:0]    NC9       = 9'(NODE_COUNT);
   localparam logic [PW-1:0] PEER_LAST = PW'(PEER_SLOTS - 1);

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_DECIDE    = 6'b000010,
      ST_ROUTE_CHK = 6'b000100,
      ST_PEER_SCAN = 6'b001000,
      ST_PEER_UPD  = 6'b010000,
      ST_FINISH    = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [1:0] cmd_ff, cmd_in;
   logic [6:0] len_ff, len_in;
   logic [7:0] sender_ff, sender_in;
   logic [7:0] rcpt_ff, rcpt_in;
   logic [7:0] seq_ff, seq_in;
   logic [7:0] port_ff, port_in;
   logic [7:0] hops_ff, hops_in;
   logic       lqf_ff, lqf_in;
   logic       txf_ff, txf_in;
   logic [3:0] dest_ff, dest_in;
   logic [7:0] nhop_ff, nhop_in;

   logic [NODE_COUNT-1:0] rvalid_ff, rvalid_in;
   logic [PEER_SLOTS-1:0] pvalid_ff, pvalid_in;
   logic [PW-1:0]         fill_ff, fill_in;
   logic [PW-1:0]         scan_ff, scan_in;
   logic [PW-1:0]         prev_ff, prev_in;
   logic                  look_ff, look_in;
   logic                  issued_ff, issued_in;
   logic [PW-1:0]         slot_ff, slot_in;
   logic [7:0]            oldseq_ff, oldseq_in;

   logic [3:0] res_verdict_ff, res_verdict_in;
   logic [7:0] res_hop_ff, res_hop_in;
   logic [6:0] res_len_ff, res_len_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [3:0] rsp_verdict_ff, rsp_verdict_in;
   logic [7:0] rsp_hop_ff, rsp_hop_in;
   logic [6:0] rsp_len_ff, rsp_len_in;

   logic [8:0]    rcpt_wide, dest_wide;
   logic [NW-1:0] rcpt_idx, dest_idx;
   logic          rcpt_in_range, dest_in_range;
   logic          route_we;
   logic [7:0]    route_rdata;
   logic [7:0]    entry;
   logic          peer_we;
   logic [15:0]   peer_wdata;
   logic [15:0]   peer_rdata;
   logic          dup;

   assign rcpt_wide     = {1'b0, rcpt_ff};
   assign dest_wide     = {5'd0, dest_ff};
   assign rcpt_idx      = rcpt_wide[NW-1:0];
   assign dest_idx      = dest_wide[NW-1:0];
   assign rcpt_in_range = rcpt_wide < NC9;
   assign dest_in_range = dest_wide < NC9;
   assign entry         = rvalid_ff[rcpt_idx] ? route_rdata : mmrf_pkg::ROUTE_NONE;
   assign dup           = oldseq_ff == seq_ff;

   mmrf_ram #(
      .WIDTH (8),
      .DEPTH (NODE_COUNT)
   ) u_route_ram (
      .clock   (clock),
      .wr_en   (route_we),
      .wr_addr (dest_idx),
      .wr_data (nhop_ff),
      .rd_addr (rcpt_idx),
      .rd_data (route_rdata)
   );

   // peer entry: sender id in the upper byte, last sequence in the lower
   mmrf_ram #(
      .WIDTH (16),
      .DEPTH (PEER_SLOTS)
   ) u_peer_ram (
      .clock   (clock),
      .wr_en   (peer_we),
      .wr_addr (slot_ff),
      .wr_data (peer_wdata),
      .rd_addr (scan_ff),
      .rd_data (peer_rdata)
   );

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      len_in         = len_ff;
      sender_in      = sender_ff;
      rcpt_in        = rcpt_ff;
      seq_in         = seq_ff;
      port_in        = port_ff;
      hops_in        = hops_ff;
      lqf_in         = lqf_ff;
      txf_in         = txf_ff;
      dest_in        = dest_ff;
      nhop_in        = nhop_ff;
      rvalid_in      = rvalid_ff;
      pvalid_in      = pvalid_ff;
      fill_in        = fill_ff;
      scan_in        = scan_ff;
      prev_in        = prev_ff;
      look_in        = look_ff;
      issued_in      = issued_ff;
      slot_in        = slot_ff;
      oldseq_in      = oldseq_ff;
      res_verdict_in = res_verdict_ff;
      res_hop_in     = res_hop_ff;
      res_len_in     = res_len_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_hop_in     = rsp_hop_ff;
      rsp_len_in     = rsp_len_ff;
      req_ready      = 1'b0;
      route_we       = 1'b0;
      peer_we        = 1'b0;
      peer_wdata     = {sender_ff, dup ? oldseq_ff : seq_ff};

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in    = req_command;
               len_in    = req_payload_length;
               sender_in = req_sender;
               rcpt_in   = req_recipient;
               seq_in    = req_sequence_req;
               port_in   = req_port;
               hops_in   = req_hop_count;
               lqf_in    = req_listener_queue_full;
               txf_in    = req_send_queue_full;
               dest_in   = req_route_destination;
               nhop_in   = req_route_relay_node;
               state_in  = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            res_hop_in = 8'd0;
            res_len_in = 7'd0;
            state_in   = ST_FINISH;
            if (cmd_ff != mmrf_pkg::CMD_MESSAGE) begin
               res_verdict_in = mmrf_pkg::V_FORWARD;
               if (dest_in_range && cmd_ff == mmrf_pkg::CMD_ROUTE_WRITE) begin
                  route_we            = 1'b1;
                  rvalid_in[dest_idx] = 1'b1;
               end
               if (dest_in_range && cmd_ff == mmrf_pkg::CMD_ROUTE_CLEAR) begin
                  rvalid_in[dest_idx] = 1'b0;
               end
            end else if (len_ff < mmrf_pkg::HDR_BYTES) begin
               res_verdict_in = mmrf_pkg::V_SHORT;
            end else if (rcpt_ff == cfg.own_node_id || rcpt_ff == cfg.broadcast_id) begin
               scan_in   = '0;
               look_in   = 1'b0;
               issued_in = 1'b0;
               state_in  = ST_PEER_SCAN;
            end else if (sender_ff == cfg.own_node_id) begin
               res_verdict_in = mmrf_pkg::V_RETURNED;
            end else if (hops_ff >= {4'd0, cfg.hop_limit}) begin
               res_verdict_in = mmrf_pkg::V_HOP_LIMIT;
            end else if (txf_ff) begin
               res_verdict_in = mmrf_pkg::V_QUEUE_FULL;
            end else if (!rcpt_in_range) begin
               res_verdict_in = mmrf_pkg::V_NO_ROUTE;
            end else begin
               state_in = ST_ROUTE_CHK;
            end
         end
         ST_ROUTE_CHK: begin
            state_in = ST_FINISH;
            if (entry == mmrf_pkg::ROUTE_NONE || {1'b0, entry} >= NC9) begin
               res_verdict_in = mmrf_pkg::V_NO_ROUTE;
            end else begin
               res_verdict_in = mmrf_pkg::V_FORWARD;
               res_hop_in     = entry;
            end
         end
         ST_PEER_SCAN: begin
            // read slot n while comparing slot n-1
            if (!issued_ff) begin
               look_in = 1'b1;
               prev_in = scan_ff;
               if (scan_ff == PEER_LAST) begin
                  issued_in = 1'b1;
               end else begin
                  scan_in = scan_ff + PW'(1);
               end
            end else begin
               look_in = 1'b0;
            end
            if (look_ff) begin
               if (pvalid_ff[prev_ff] && peer_rdata[15:8] == sender_ff) begin
                  slot_in   = prev_ff;
                  oldseq_in = peer_rdata[7:0];
                  state_in  = ST_PEER_UPD;
               end else if (prev_ff == PEER_LAST) begin
                  // new peer takes the slot at the fill pointer
                  slot_in            = fill_ff;
                  oldseq_in          = 8'd0;
                  pvalid_in[fill_ff] = 1'b1;
                  fill_in            = (fill_ff == PEER_LAST) ? '0 : fill_ff + PW'(1);
                  state_in           = ST_PEER_UPD;
               end
            end
         end
         ST_PEER_UPD: begin
            peer_we  = 1'b1;
            state_in = ST_FINISH;
            if (dup) begin
               res_verdict_in = mmrf_pkg::V_DUPLICATE;
            end else if (port_ff[7:4] != 4'd0 || !cfg.listener_ports[port_ff[3:0]]) begin
               res_verdict_in = mmrf_pkg::V_NO_LISTENER;
            end else if (lqf_ff) begin
               res_verdict_in = mmrf_pkg::V_LISTENER_FULL;
            end else begin
               res_verdict_in = mmrf_pkg::V_DELIVER;
               res_len_in     = len_ff - mmrf_pkg::HDR_BYTES;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = res_verdict_ff;
               rsp_hop_in     = res_hop_ff;
               rsp_len_in     = res_len_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rvalid_ff    <= '0;
         pvalid_ff    <= '0;
         fill_ff      <= '0;
         scan_ff      <= '0;
         look_ff      <= 1'b0;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rvalid_ff    <= rvalid_in;
         pvalid_ff    <= pvalid_in;
         fill_ff      <= fill_in;
         scan_ff      <= scan_in;
         look_ff      <= look_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      len_ff         <= len_in;
      sender_ff      <= sender_in;
      rcpt_ff        <= rcpt_in;
      seq_ff         <= seq_in;
      port_ff        <= port_in;
      hops_ff        <= hops_in;
      lqf_ff         <= lqf_in;
      txf_ff         <= txf_in;
      dest_ff        <= dest_in;
      nhop_ff        <= nhop_in;
      prev_ff        <= prev_in;
      slot_ff        <= slot_in;
      oldseq_ff      <= oldseq_in;
      res_verdict_ff <= res_verdict_in;
      res_hop_ff     <= res_hop_in;
      res_len_ff     <= res_len_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_hop_ff     <= rsp_hop_in;
      rsp_len_ff     <= rsp_len_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_verdict     = rsp_verdict_ff;
   assign rsp_relay_node  = rsp_hop_ff;
   assign rsp_data_length = rsp_len_ff;

endmodule

// ===== verif/tb_mesh_message_receive_filter.sv =====
`timescale 1ns / 1ps

module tb_mesh_message_receive_filter;

   localparam int NODE_COUNT = mmrf_pkg::NODE_COUNT_DEF;
   localparam int PEER_SLOTS = mmrf_pkg::PEER_SLOTS_DEF;
   localparam logic [1:0] CMD_MSG = mmrf_pkg::CMD_MESSAGE;
   localparam logic [1:0] CMD_WR = mmrf_pkg::CMD_ROUTE_WRITE;
   localparam logic [1:0] CMD_CLR = mmrf_pkg::CMD_ROUTE_CLEAR;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int COMPUTED = -1;
   localparam int PHASES = 5;
   localparam int PHASE_ITEMS = 345;
   localparam int LONG_HOLD = 300;
   localparam int QUIET_LIMIT = 4000;

   typedef struct {
      logic [1:0] command;
      logic [6:0] payload_length;
      logic [7:0] sender;
      logic [7:0] recipient;
      logic [7:0] sequence_req;
      logic [7:0] port;
      logic [7:0] hop_count;
      logic       listener_queue_full;
      logic       send_queue_full;
      logic [3:0] route_destination;
      logic [7:0] route_relay_node;
   } msg_item_type;

   typedef struct {
      logic [3:0] verdict;
      logic [7:0] relay_node;
      logic [6:0] data_length;
   } verdict_type;

   typedef struct {
      msg_item_type item;
      bit           typed;
      logic [3:0]   verdict;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [mmrf_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [mmrf_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [mmrf_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_command = '0;
   logic [6:0] req_payload_length = '0;
   logic [7:0] req_sender = '0;
   logic [7:0] req_recipient = '0;
   logic [7:0] req_sequence_req = '0;
   logic [7:0] req_port = '0;
   logic [7:0] req_hop_count = '0;
   logic req_listener_queue_full = 1'b0;
   logic req_send_queue_full = 1'b0;
   logic [3:0] req_route_destination = '0;
   logic [7:0] req_route_relay_node = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [3:0] rsp_verdict;
   logic [7:0] rsp_relay_node;
   logic [6:0] rsp_data_length;

   mesh_message_receive_filter dut (.*);

   always #5 clock = ~clock;

   // block state as tracked by the testbench
   mmrf_pkg::cfg_type model_cfg;
   logic [7:0] route_next[NODE_COUNT];
   logic [7:0] peer_id[PEER_SLOTS];
   bit         peer_used[PEER_SLOTS];
   logic [7:0] peer_seq[PEER_SLOTS];
   int         peer_fill;

   verdict_type      pending_verdicts[$];
   directed_row_type directed_rows[$];
   int errors = 0;
   int results_seen = 0;
   int quiet_cycles = 0;
   int tx_idle_pct = 30;
   int rx_idle_pct = 80;
   bit hold_done = 1'b0;

   function automatic int peer_slot(input logic [7:0] who);
      int slot;
      for (int i = 0; i < PEER_SLOTS; i++) begin
         if (peer_used[i] && peer_id[i] == who) return i;
      end
      slot = peer_fill % PEER_SLOTS;
      peer_id[slot] = who;
      peer_used[slot] = 1'b1;
      peer_seq[slot] = 8'd0;
      peer_fill = (slot + 1) % PEER_SLOTS;
      return slot;
   endfunction

   function automatic verdict_type classify_message(input msg_item_type it);
      verdict_type r;
      int slot;
      logic [7:0] entry;
      r = '{mmrf_pkg::V_FORWARD, 8'd0, 7'd0};
      if (it.payload_length < mmrf_pkg::HDR_BYTES) begin
         r.verdict = mmrf_pkg::V_SHORT;
      end else if (it.recipient == model_cfg.own_node_id ||
                   it.recipient == model_cfg.broadcast_id) begin
         slot = peer_slot(it.sender);
         if (peer_seq[slot] == it.sequence_req) begin
            r.verdict = mmrf_pkg::V_DUPLICATE;
         end else begin
            peer_seq[slot] = it.sequence_req;
            if (it.port > 8'd15 || !model_cfg.listener_ports[it.port[3:0]]) begin
               r.verdict = mmrf_pkg::V_NO_LISTENER;
            end else if (it.listener_queue_full) begin
               r.verdict = mmrf_pkg::V_LISTENER_FULL;
            end else begin
               r.verdict = mmrf_pkg::V_DELIVER;
               r.data_length = it.payload_length - mmrf_pkg::HDR_BYTES;
            end
         end
      end else if (it.sender == model_cfg.own_node_id) begin
         r.verdict = mmrf_pkg::V_RETURNED;
      end else if (it.hop_count >= model_cfg.hop_limit) begin
         r.verdict = mmrf_pkg::V_HOP_LIMIT;
      end else if (it.send_queue_full) begin
         r.verdict = mmrf_pkg::V_QUEUE_FULL;
      end else if (it.recipient >= NODE_COUNT) begin
         r.verdict = mmrf_pkg::V_NO_ROUTE;
      end else begin
         entry = route_next[it.recipient];
         if (entry == mmrf_pkg::ROUTE_NONE || entry >= NODE_COUNT) begin
            r.verdict = mmrf_pkg::V_NO_ROUTE;
         end else begin
            r.relay_node = entry;
         end
      end
      return r;
   endfunction

   function automatic verdict_type predict_verdict(input msg_item_type it);
      verdict_type r;
      r = '{mmrf_pkg::V_FORWARD, 8'd0, 7'd0};
      case (it.command)
         CMD_MSG: r = classify_message(it);
         CMD_WR: begin
            if (it.route_destination < NODE_COUNT)
               route_next[it.route_destination] = it.route_relay_node;
         end
         CMD_CLR: begin
            if (it.route_destination < NODE_COUNT)
               route_next[it.route_destination] = mmrf_pkg::ROUTE_NONE;
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic void add_row(input logic [1:0] cmd, input int len, input int snd,
                                   input int rcp, input int seq, input int port,
                                   input int hops, input bit lqf, input bit sqf,
                                   input int dest, input int nh, input int verdict_code);
      directed_row_type row;
      row.item = '{cmd, 7'(len), 8'(snd), 8'(rcp), 8'(seq), 8'(port), 8'(hops),
                   lqf, sqf, 4'(dest), 8'(nh)};
      row.typed = (verdict_code != COMPUTED);
      row.verdict = 4'(verdict_code);
      directed_rows.push_back(row);
   endfunction

   function automatic msg_item_type random_item();
      msg_item_type it;
      int pick;
      it = '{CMD_MSG, 7'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
             8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom), 4'($urandom),
             8'($urandom)};
      pick = $urandom_range(99);
      if (pick < 10) begin
         pick = $urandom_range(9);
         it.command = (pick < 6) ? CMD_WR : (pick < 9) ? CMD_CLR : CMD_UNUSED;
         pick = $urandom_range(9);
         if (pick < 7) it.route_relay_node = 8'($urandom_range(NODE_COUNT - 1));
         else if (pick < 9) it.route_relay_node = mmrf_pkg::ROUTE_NONE;
      end else begin
         if ($urandom_range(9) == 0)
            it.payload_length = 7'($urandom_range(mmrf_pkg::HDR_BYTES - 1));
         else
            it.payload_length = 7'($urandom_range(127, mmrf_pkg::HDR_BYTES));
         pick = $urandom_range(99);
         if (pick < 25) it.recipient = model_cfg.own_node_id;
         else if (pick < 45) it.recipient = model_cfg.broadcast_id;
         else if (pick < 85) it.recipient = 8'($urandom_range(NODE_COUNT - 1));
         pick = $urandom_range(99);
         if (pick < 70) it.sender = 8'($urandom_range(11));
         else if (pick < 80) it.sender = model_cfg.own_node_id;
         if ($urandom_range(1)) it.sequence_req = 8'($urandom_range(3));
         if ($urandom_range(4) != 0) it.port = 8'($urandom_range(15));
         if ($urandom_range(4) != 0) it.hop_count = 8'($urandom_range(15));
         it.listener_queue_full = ($urandom_range(4) == 0);
         it.send_queue_full = ($urandom_range(6) == 0);
      end
      return it;
   endfunction

   task automatic send_item(input msg_item_type it, input bit typed,
                            input logic [3:0] verdict);
      verdict_type r;
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= it.command;
      req_payload_length <= it.payload_length;
      req_sender <= it.sender;
      req_recipient <= it.recipient;
      req_sequence_req <= it.sequence_req;
      req_port <= it.port;
      req_hop_count <= it.hop_count;
      req_listener_queue_full <= it.listener_queue_full;
      req_send_queue_full <= it.send_queue_full;
      req_route_destination <= it.route_destination;
      req_route_relay_node <= it.route_relay_node;
      do @(posedge clock); while (!req_ready);
      r = predict_verdict(it);
      if (typed) r = '{verdict, 8'd0, 7'd0};
      pending_verdicts.push_back(r);
   endtask

   task automatic write_reg(input logic [1:0] index,
                            input logic [mmrf_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== value) begin
         $error("csr_prdata at %0d: expected %h, actual %h", index, value, csr_prdata);
         errors++;
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic apply_config(input mmrf_pkg::cfg_type c);
      write_reg(mmrf_pkg::REG_OWN_NODE_ID, mmrf_pkg::CSR_DATA_W'(c.own_node_id));
      write_reg(mmrf_pkg::REG_BROADCAST_ID, mmrf_pkg::CSR_DATA_W'(c.broadcast_id));
      write_reg(mmrf_pkg::REG_LISTENER_PORTS, mmrf_pkg::CSR_DATA_W'(c.listener_ports));
      write_reg(mmrf_pkg::REG_HOP_LIMIT, mmrf_pkg::CSR_DATA_W'(c.hop_limit));
      model_cfg = c;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (PEER_SLOTS + 4) @(posedge clock);
   endtask

   // result side: random stalls plus one long hold-off once traffic is flowing
   initial begin
      forever begin
         @(negedge clock);
         if (!hold_done && results_seen >= 100) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_verdicts.size() == 0) begin
            $error("result with no item pending: verdict %0d", rsp_verdict);
            errors++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_verdict !== want.verdict) begin
               $error("verdict: expected %0d, actual %0d", want.verdict, rsp_verdict);
               errors++;
            end
            if (rsp_relay_node !== want.relay_node) begin
               $error("relay_node: expected %0d, actual %0d", want.relay_node,
                      rsp_relay_node);
               errors++;
            end
            if (rsp_data_length !== want.data_length) begin
               $error("data_length: expected %0d, actual %0d", want.data_length,
                      rsp_data_length);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_mesh_message_receive_filter: FAIL");
         $finish;
      end
   end

   initial begin
      mmrf_pkg::cfg_type phase_cfg[PHASES];
      mmrf_pkg::cfg_type c;

      model_cfg = '{mmrf_pkg::OWN_NODE_ID_RST, mmrf_pkg::BROADCAST_ID_RST,
                    mmrf_pkg::LISTENER_PORTS_RST, mmrf_pkg::HOP_LIMIT_RST};
      foreach (route_next[i]) route_next[i] = mmrf_pkg::ROUTE_NONE;
      foreach (peer_id[i]) begin
         peer_id[i] = 8'd0;
         peer_used[i] = 1'b0;
         peer_seq[i] = 8'd0;
      end
      peer_fill = 0;

      // cmd, len, sender, recipient, seq, port, hops, lq full, tx full, dest, relay
      add_row(CMD_MSG,      0,   0,   0,   0,   0,   0, 0, 0,  0,   0, mmrf_pkg::V_SHORT);
      add_row(CMD_MSG,      4, 255, 255, 255, 255, 255, 1, 1, 15, 255, mmrf_pkg::V_SHORT);
      add_row(CMD_UNUSED,  20,   5,   3,   0,   0,   0, 0, 0,  0,   0, mmrf_pkg::V_FORWARD);
      add_row(CMD_WR,      20,   5,   3,   0,   0,   0, 0, 0,  3,   7, mmrf_pkg::V_FORWARD);
      add_row(CMD_MSG,     20,   5,   3,   0,   0,   0, 0, 0,  0,   0, COMPUTED);
      add_row(CMD_MSG,    127,   5, 200,   0,   0,   0, 0, 0,  0,   0, mmrf_pkg::V_NO_ROUTE);
      add_row(CMD_WR,      20,   5,   3,   0,   0,   0, 0, 0,  4, 200, mmrf_pkg::V_FORWARD);
      add_row(CMD_MSG,     20,   5,   4,   0,   0,   0, 0, 0,  0,   0, COMPUTED);
      add_row(CMD_WR,      20,   5,   3,   0,   0,   0, 0, 0, 15,  15, mmrf_pkg::V_FORWARD);
      add_row(CMD_MSG,     20,   5,  15,   0,   0,   7, 0, 0,  0,   0, COMPUTED);
      add_row(CMD_CLR,     20,   5,   3,   0,   0,   0, 0, 0,  3,   0, mmrf_pkg::V_FORWARD);
      add_row(CMD_MSG,     20,   5,   3,   0,   0,   0, 0, 0,  0,   0, COMPUTED);
      add_row(CMD_MSG,     20,   1,   3,   0,   0,   0, 0, 0,  0,   0, mmrf_pkg::V_RETURNED);
      add_row(CMD_MSG,     20,   5,   3,   0,   0,   8, 0, 0,  0,   0, mmrf_pkg::V_HOP_LIMIT);
      add_row(CMD_MSG,     20,   5,  15,   0,   0,   7, 0, 1,  0,   0, mmrf_pkg::V_QUEUE_FULL);
      add_row(CMD_MSG,     20,   9,   1,   0,   0,   0, 0, 0,  0,   0, COMPUTED);
      add_row(CMD_MSG,    127,   9,   1,   5,   0,   0, 0, 0,  0,   0, COMPUTED);
      add_row(CMD_MSG,    127,   9,   1,   5,   0,   0, 0, 0,  0,   0, COMPUTED);
      add_row(CMD_MSG,     20,   9, 255,   6,  15,   0, 1, 0,  0,   0, COMPUTED);
      add_row(CMD_MSG,     20,   9, 255,   7,  16,   0, 0, 0,  0,   0, COMPUTED);
      add_row(CMD_MSG,     20,   9,   1,   8,   1,   0, 0, 0,  0,   0, COMPUTED);
      add_row(CMD_MSG,      5,   0,   1, 255,   0,   0, 0, 0,  0,   0, COMPUTED);
      add_row(CMD_WR,      20,   5,   3,   0,   0,   0, 0, 0,  0,   0, mmrf_pkg::V_FORWARD);
      add_row(CMD_MSG,     20,   2,   0,   0,   0,   0, 0, 0,  0,   0, COMPUTED);

      phase_cfg[0] = '{8'($urandom_range(15)), 8'($urandom), 16'($urandom), 4'($urandom)};
      phase_cfg[1] = '{8'd0, 8'd0, 16'h0000, 4'd0};
      phase_cfg[2] = '{8'd255, 8'd255, 16'hFFFF, 4'd15};
      phase_cfg[3] = '{8'($urandom_range(15)), 8'($urandom), 16'($urandom), 4'($urandom)};
      phase_cfg[4] = '{8'($urandom_range(15)), 8'($urandom), 16'($urandom), 4'($urandom)};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ports 0 and 15 listening for the directed part
      c = model_cfg;
      c.listener_ports = 16'h8001;
      apply_config(c);
      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].verdict);

      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         apply_config(phase_cfg[p]);
         tx_idle_pct = (p < 2) ? 30 : (p < 4) ? 80 : 0;
         rx_idle_pct = (p < 2) ? 80 : (p < 4) ? 30 : 0;
         repeat (PHASE_ITEMS) send_item(random_item(), 1'b0, mmrf_pkg::V_FORWARD);
      end

      wait_drained();
      if (errors == 0 && pending_verdicts.size() == 0) begin
         $display("tb_mesh_message_receive_filter: PASS");
      end else begin
         $display("tb_mesh_message_receive_filter: FAIL");
      end
      $finish;
   end

endmodule
